// ----- sv/esl_pkg.sv -----
// shared types, constants and register map of the encoder speed low-pass block
`default_nettype none
package esl_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned CoefWidth  = 16;
   localparam int unsigned ScaleWidth = 10;
   localparam int unsigned SpeedWidth = 16;
   localparam int unsigned FiltWidth  = 34;
   localparam int unsigned FracWidth  = 16;
   localparam int unsigned MulWidth   = 18;
   localparam int unsigned ProdWidth  = 2 * MulWidth;
   localparam int unsigned AccWidth   = 51;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [CsrIdxWidth-1:0] REG_COEF_FEEDBACK = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_COEF_INPUT    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] REG_RPM_SCALE     = 2'd2;

   localparam logic [CoefWidth-1:0]  COEF_FEEDBACK_RESET = 16'd63511;
   localparam logic [CoefWidth-1:0]  COEF_INPUT_RESET    = 16'd2027;
   localparam logic [ScaleWidth-1:0] RPM_SCALE_RESET     = 10'd30;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW,
      ST_LO,
      ST_HI,
      ST_IN,
      ST_SUM
   } esl_state_type;

   typedef struct packed {
      logic [CoefWidth-1:0]  coef_feedback;
      logic [CoefWidth-1:0]  coef_input;
      logic [ScaleWidth-1:0] rpm_scale;
   } esl_cfg_type;

endpackage
`default_nettype wire

// ----- sv/esl_csr.sv -----
// configuration registers of the encoder speed low-pass block
`default_nettype none
module esl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [esl_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [esl_pkg::CsrDataWidth-1:0]  csr_wdata,
   output esl_pkg::esl_cfg_type                   cfg
);
   import esl_pkg::*;

   esl_cfg_type cfg_ff;
   esl_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_COEF_FEEDBACK: cfg_in.coef_feedback = csr_wdata[CoefWidth-1:0];
            REG_COEF_INPUT:    cfg_in.coef_input    = csr_wdata[CoefWidth-1:0];
            REG_RPM_SCALE:     cfg_in.rpm_scale     = csr_wdata[ScaleWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_feedback <= COEF_FEEDBACK_RESET;
         cfg_ff.coef_input    <= COEF_INPUT_RESET;
         cfg_ff.rpm_scale     <= RPM_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- sv/esl_mul.sv -----
// shared registered signed multiplier
`default_nettype none
module esl_mul (
   input  wire logic                                clock,
   input  wire logic                                mul_en,
   input  wire logic signed [esl_pkg::MulWidth-1:0] op_a,
   input  wire logic signed [esl_pkg::MulWidth-1:0] op_b,
   output logic signed [esl_pkg::ProdWidth-1:0]     prod
);
   import esl_pkg::*;

   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [ProdWidth-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ----- sv/encoder_speed_lowpass_core.sv -----
// top level: encoder edge counter, speed scaling and first-order low-pass filter
//
// channel  direction  tdata                tuser
// req      in         [0] phase_b          [0] cmd (0 edge, 1 tick)
// rsp      out        [15:0] speed_rpm     [0] reverse
// csr      in         write port: csr_we, csr_index, csr_wdata
//
// an edge transfer updates the counter and req_tready stays high
// a tick transfer steps through ST_RAW to ST_SUM: one shared 18x18 multiplier runs four
// products in turn (count*scale, a*y low, a*y high, b*raw), then the sum
// the final step holds while the previous result still waits on rsp_tready
// synchronous active-high reset clears counter, filter state and valids
`default_nettype none
module encoder_speed_lowpass_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // [0] phase_b
   input  wire logic                             req_tuser,  // [0] cmd
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,  // [15:0] speed_rpm
   output logic                                  rsp_tuser,  // [0] reverse
   input  wire logic                             csr_we,
   input  wire logic [esl_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [esl_pkg::CsrDataWidth-1:0] csr_wdata
);
   import esl_pkg::*;

   esl_cfg_type cfg;
   esl_state_type state_ff, state_in;

   logic [CountWidth-1:0]        count_ff, count_in;
   logic signed [FiltWidth-1:0]  y_ff, y_in;
   logic signed [SpeedWidth-1:0] raw_ff, raw_in;
   logic signed [AccWidth-1:0]   acc_ff, acc_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SpeedWidth-1:0] speed_ff, speed_in;
   logic                         rev_ff, rev_in;

   logic                         mul_en;
   logic signed [MulWidth-1:0]   mul_a, mul_b;
   logic signed [ProdWidth-1:0]  prod;

   logic                         req_fire;
   logic signed [ProdWidth-1:0]  sum_w;
   logic signed [FiltWidth-1:0]  ysat_w;
   logic signed [FiltWidth-FracWidth-1:0] tq_w;
   logic signed [SpeedWidth-1:0] spd_w;

   esl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esl_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // filter sum, 34-bit saturation, truncation toward zero, 16-bit saturation
   always_comb begin
      sum_w = {acc_ff[AccWidth-1], acc_ff[AccWidth-1:FracWidth]} + prod;
      if (sum_w > $signed(36'sh1_FFFF_FFFF)) begin
         ysat_w = {1'b0, {(FiltWidth-1){1'b1}}};
      end else if (sum_w < -$signed(36'sh2_0000_0000)) begin
         ysat_w = {1'b1, {(FiltWidth-1){1'b0}}};
      end else begin
         ysat_w = sum_w[FiltWidth-1:0];
      end
      tq_w = ysat_w[FiltWidth-1:FracWidth];
      if (ysat_w[FiltWidth-1] && (ysat_w[FracWidth-1:0] != '0)) begin
         tq_w = tq_w + 18'sd1;
      end
      if (tq_w > 18'sd32767) begin
         spd_w = 16'sh7FFF;
      end else if (tq_w < -18'sd32768) begin
         spd_w = 16'sh8000;
      end else begin
         spd_w = tq_w[SpeedWidth-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      y_in         = y_ff;
      raw_in       = raw_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      speed_in     = speed_ff;
      rev_in       = rev_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_TICK) begin
                  state_in = ST_RAW;
               end else if (req_tdata[0]) begin
                  count_in = count_ff - 16'd1;
               end else begin
                  count_in = count_ff + 16'd1;
               end
            end
         end
         ST_RAW: begin
            mul_en   = 1'b1;
            mul_a    = {{2{count_ff[CountWidth-1]}}, count_ff};
            mul_b    = {8'd0, cfg.rpm_scale};
            count_in = '0;
            state_in = ST_LO;
         end
         ST_LO: begin
            if (prod > 36'sd32767) begin
               raw_in = 16'sh7FFF;
            end else if (prod < -36'sd32768) begin
               raw_in = 16'sh8000;
            end else begin
               raw_in = prod[SpeedWidth-1:0];
            end
            mul_en   = 1'b1;
            mul_a    = {2'b00, cfg.coef_feedback};
            mul_b    = {1'b0, y_ff[16:0]};
            state_in = ST_HI;
         end
         ST_HI: begin
            acc_in   = {{(AccWidth-ProdWidth){prod[ProdWidth-1]}}, prod};
            mul_en   = 1'b1;
            mul_a    = {2'b00, cfg.coef_feedback};
            mul_b    = {y_ff[FiltWidth-1], y_ff[FiltWidth-1:17]};
            state_in = ST_IN;
         end
         ST_IN: begin
            acc_in   = {prod[33:0], 17'd0} + acc_ff;
            mul_en   = 1'b1;
            mul_a    = {2'b00, cfg.coef_input};
            mul_b    = {{2{raw_ff[SpeedWidth-1]}}, raw_ff};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!rsp_valid_ff || rsp_tready) begin
               y_in         = ysat_w;
               speed_in     = spd_w;
               rev_in       = spd_w[SpeedWidth-1];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         y_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         y_ff         <= y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      acc_ff   <= acc_in;
      speed_ff <= speed_in;
      rev_ff   <= rev_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = speed_ff;
   assign rsp_tuser  = rev_ff;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the encoder speed low-pass core: edge and tick streams against a predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import esl_pkg::*;

   localparam logic [CsrIdxWidth-1:0] REG_SPARE = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;
   localparam longint FILT_MAX = 64'sd8589934591;
   localparam longint FILT_MIN = -64'sd8589934592;

   typedef struct packed {
      logic cmd;
      logic phase_b;
   } encoder_event_type;

   typedef struct packed {
      logic [SpeedWidth-1:0] speed_rpm;
      logic                  reverse;
   } speed_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = 8'h00;  // [0] phase_b
   logic                    req_tuser = 1'b0;   // [0] cmd
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [15:0]             rsp_tdata;          // [15:0] speed_rpm
   logic                    rsp_tuser;          // [0] reverse
   logic                    csr_we = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // predictor state and register copies
   logic [CoefWidth-1:0]   feedback_coef = COEF_FEEDBACK_RESET;
   logic [CoefWidth-1:0]   input_coef = COEF_INPUT_RESET;
   logic [ScaleWidth-1:0]  count_scale = RPM_SCALE_RESET;
   logic signed [15:0]     edge_tally = '0;
   longint                 filtered_q16 = 0;

   encoder_event_type pending_events[$];
   speed_result_type  expected_speeds[$];
   int unsigned    queued_count = 0;
   int unsigned    accepted_count = 0;
   longint unsigned cycle_count = 0;
   bit             failed = 1'b0;
   bit             quiet_tail = 1'b0;
   bit             hold_armed = 1'b0;
   logic           req_taken = 1'b0;

   encoder_speed_lowpass_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void advance_speed_filter(logic cmd, logic phase_b);
      longint raw;
      longint y;
      longint whole;
      speed_result_type res;
      if (cmd == CMD_EDGE) begin
         edge_tally = phase_b ? edge_tally - 16'sd1 : edge_tally + 16'sd1;
      end else begin
         raw = longint'(edge_tally) * longint'(count_scale);
         if (raw > 32767) raw = 32767;
         if (raw < -32768) raw = -32768;
         edge_tally = '0;
         y = (longint'(feedback_coef) * filtered_q16) >>> FracWidth;
         y = y + longint'(input_coef) * raw;
         if (y > FILT_MAX) y = FILT_MAX;
         if (y < FILT_MIN) y = FILT_MIN;
         filtered_q16 = y;
         whole = y / 64'sd65536;
         if (whole > 32767) whole = 32767;
         if (whole < -32768) whole = -32768;
         res.speed_rpm = whole[SpeedWidth-1:0];
         res.reverse = (whole < 0);
         expected_speeds.push_back(res);
      end
   endfunction

   task automatic push_item(logic cmd, logic phase_b);
      encoder_event_type ev;
      ev.cmd = cmd;
      ev.phase_b = phase_b;
      pending_events.push_back(ev);
      queued_count++;
   endtask

   // runs of edges mostly in one direction, each closed by a tick
   task automatic queue_runs(int unsigned count, int unsigned lean_up);
      int unsigned added;
      int unsigned run_len;
      int unsigned k;
      logic heading;
      added = 0;
      while (added < count) begin
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
         heading = ($urandom_range(0, 99) < lean_up) ? 1'b0 : 1'b1;
         for (k = 0; k < run_len; k++) begin
            push_item(CMD_EDGE, ($urandom_range(0, 9) == 0) ? ~heading : heading);
         end
         push_item(CMD_TICK, 1'($urandom_range(0, 1)));
         added += run_len + 1;
      end
   endtask

   task automatic write_reg(logic [CsrIdxWidth-1:0] index, logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_COEF_FEEDBACK: feedback_coef = value;
         REG_COEF_INPUT: input_coef = value;
         REG_RPM_SCALE: count_scale = value[ScaleWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_filter(logic [15:0] a, logic [15:0] b, logic [15:0] scale);
      write_reg(REG_COEF_FEEDBACK, a);
      write_reg(REG_COEF_INPUT, b);
      write_reg(REG_RPM_SCALE, scale);
   endtask

   task automatic drain_block();
      while (accepted_count != queued_count || expected_speeds.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty tick, up and down counts, mixed directions
      push_item(CMD_TICK, 1'b0);
      repeat (3) push_item(CMD_EDGE, 1'b0);
      push_item(CMD_TICK, 1'b1);
      repeat (2) push_item(CMD_EDGE, 1'b1);
      push_item(CMD_TICK, 1'b0);
      push_item(CMD_EDGE, 1'b1);
      push_item(CMD_EDGE, 1'b0);
      push_item(CMD_TICK, 1'b0);
      drain_block();

      // filter value just below and just above zero; spare index ignored
      set_filter(16'd0, 16'd1, 16'd1);
      write_reg(REG_SPARE, 16'hFFFF);
      push_item(CMD_EDGE, 1'b1);
      push_item(CMD_TICK, 1'b0);
      push_item(CMD_EDGE, 1'b0);
      push_item(CMD_TICK, 1'b1);
      drain_block();

      // upper register bits masked, largest negative step
      write_reg(REG_COEF_INPUT, 16'hFFFF);
      write_reg(REG_RPM_SCALE, 16'hFFFF);
      push_item(CMD_EDGE, 1'b1);
      push_item(CMD_TICK, 1'b0);
      drain_block();

      // raw speed clamps at the bottom of its range
      write_reg(REG_RPM_SCALE, 16'd1023);
      repeat (40) push_item(CMD_EDGE, 1'b1);
      push_item(CMD_TICK, 1'b0);
      push_item(CMD_EDGE, 1'b0);
      push_item(CMD_TICK, 1'b0);
      drain_block();

      set_filter(COEF_FEEDBACK_RESET, COEF_INPUT_RESET, 16'(RPM_SCALE_RESET));
      hold_armed = 1'b1;
      queue_runs(200, 50);
      drain_block();

      // drive the filter into positive then negative saturation
      set_filter(16'hFFFF, 16'hFFFF, 16'd1023);
      queue_runs(200, 90);
      drain_block();
      queue_runs(200, 10);
      drain_block();

      set_filter(16'd0, 16'd0, 16'd0);
      queue_runs(150, 50);
      drain_block();

      set_filter(16'd0, 16'hFFFF, 16'd1023);
      queue_runs(150, 50);
      drain_block();

      set_filter(16'($urandom), 16'($urandom), 16'($urandom));
      write_reg(REG_SPARE, 16'($urandom));
      queue_runs(200, 50);
      drain_block();

      quiet_tail = 1'b1;
      set_filter(16'($urandom_range(60000, 65535)), 16'($urandom), 16'($urandom_range(0, 1023)));
      queue_runs(200, 50);
      drain_block();

      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   always @(negedge clock) begin : sender
      encoder_event_type ev;
      int unsigned gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && pending_events.size() != 0 && $urandom_range(0, 6) == 0) begin
            gap_left = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {7'b0, ev.phase_b};
            req_tuser <= ev.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int unsigned hold_left;
      int unsigned idle_left;
      bit hold_used;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         idle_left = 0;
         hold_used = 1'b0;
      end else if (hold_armed && !hold_used) begin
         hold_used = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idle_left > 0) begin
         idle_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         idle_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      speed_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            accepted_count++;
            advance_speed_filter(req_tuser, req_tdata[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_speeds.size() == 0) begin
               $error("unexpected transfer: speed_rpm %0d reverse %0b",
                  $signed(rsp_tdata), rsp_tuser);
               failed = 1'b1;
            end else begin
               want = expected_speeds.pop_front();
               if (rsp_tdata !== want.speed_rpm) begin
                  $error("speed_rpm: expected %0d, got %0d",
                     $signed(want.speed_rpm), $signed(rsp_tdata));
                  failed = 1'b1;
               end
               if (rsp_tuser !== want.reverse) begin
                  $error("reverse: expected %0b, got %0b", want.reverse, rsp_tuser);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

// ----- encoder_speed_lowpass_core.f -----
sv/esl_pkg.sv
sv/esl_csr.sv
sv/esl_mul.sv
sv/encoder_speed_lowpass_core.sv
tb/sv/tb_top.sv
